FILE: src/lngh_pkg.sv
// ----------------------------------------------------------------------------
// lngh_pkg
// Shared codes and controller/datapath command and status types for the
// letter n-gram histogram.
// ----------------------------------------------------------------------------
package lngh_pkg;

  localparam logic [1:0] OP_FEED  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] TBL_UNI = 2'd0;
  localparam logic [1:0] TBL_BI  = 2'd1;
  localparam logic [1:0] TBL_TRI = 2'd2;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

  typedef struct packed {
    logic load_in;
    logic mem_rd;
    logic feed_wr;
    logic capture;
    logic div_step;
    logic round;
    logic clr_start;
    logic clr_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       sweep_done;
    logic       div_last;
  } dp_status_t;

endpackage

FILE: src/lngh_ctrl.sv
// ----------------------------------------------------------------------------
// lngh_ctrl
// Sequencer for the histogram: clearing sweep, feed read-modify-write,
// readout with serial division, and the output handshake.
// ----------------------------------------------------------------------------
module lngh_ctrl
  import lngh_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  output dp_cmd_t    cmd,
  input  dp_status_t sts
);

  localparam logic [3:0] S_CLR_RST  = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DECODE   = 4'd2;
  localparam logic [3:0] S_FEED_WR  = 4'd3;
  localparam logic [3:0] S_READ_CAP = 4'd4;
  localparam logic [3:0] S_DIV      = 4'd5;
  localparam logic [3:0] S_ROUND    = 4'd6;
  localparam logic [3:0] S_CLR_OP   = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLR_RST: begin
        cmd.clr_step = 1'b1;
        if (sts.sweep_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.op)
          OP_FEED: begin
            cmd.mem_rd = 1'b1;
            state_next = S_FEED_WR;
          end
          OP_READ: begin
            cmd.mem_rd = 1'b1;
            state_next = S_READ_CAP;
          end
          OP_CLEAR: begin
            cmd.clr_start = 1'b1;
            state_next    = S_CLR_OP;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_FEED_WR: begin
        cmd.feed_wr = 1'b1;
        state_next  = S_DONE;
      end
      S_READ_CAP: begin
        cmd.capture = 1'b1;
        state_next  = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round  = 1'b1;
        state_next = S_DONE;
      end
      S_CLR_OP: begin
        cmd.clr_step = 1'b1;
        if (sts.sweep_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR_RST;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!m_tvalid || m_tready))
    else $error("result loaded over a waiting result");

  a_sweep_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR_RST || state == S_CLR_OP) && !sts.sweep_done
      |=> state == $past(state))
    else $error("clearing sweep left early");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> m_tvalid)
    else $error("loaded result not presented");

endmodule

FILE: src/lngh_datapath.sv
// ----------------------------------------------------------------------------
// lngh_datapath
// Count memories, totals, letter history, restoring divider and the output
// register of the letter n-gram histogram.
// ----------------------------------------------------------------------------
module lngh_datapath
  import lngh_pkg::*;
#(
  parameter int ALPHABET_SIZE = 26,
  parameter int COUNT_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  dp_cmd_t                  cmd,
  output dp_status_t               sts,
  input  logic [1:0]               operation,
  input  logic [7:0]               char_byte,
  input  logic [1:0]               table_select,
  input  logic [14:0]              entry_index,
  output logic                     letter_accepted,
  output logic [COUNT_WIDTH-1:0]   entry_count,
  output logic [COUNT_WIDTH-1:0]   table_total,
  output logic [FRACTION_BITS:0]   frequency_q16,
  output logic                     zero_total
);

  localparam int SIZE1 = ALPHABET_SIZE;
  localparam int SIZE2 = ALPHABET_SIZE * ALPHABET_SIZE;
  localparam int SIZE3 = ALPHABET_SIZE * ALPHABET_SIZE * ALPHABET_SIZE;
  localparam int AW1   = $clog2(SIZE1);
  localparam int AW2   = $clog2(SIZE2);
  localparam int AW3   = $clog2(SIZE3);
  localparam int DCW   = $clog2(FRACTION_BITS);
  localparam int CW    = COUNT_WIDTH;
  localparam int FB    = FRACTION_BITS;

  localparam logic [FB:0] FREQ_ONE = {1'b1, {FB{1'b0}}};

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    sat_inc = (&v) ? v : v + 1'b1;
  endfunction

  logic [1:0]  op_r;
  logic [7:0]  byte_r;
  logic [1:0]  sel_r;
  logic [14:0] idx_r;

  logic [AW1-1:0] prev;
  logic           prev_v;
  logic [AW1-1:0] sp;
  logic           sp_v;
  logic [CW-1:0]  uni_tot;
  logic [CW-1:0]  bi_tot;
  logic [CW-1:0]  tri_tot;
  logic [AW3-1:0] sweep;

  logic [CW-1:0] uni_mem [SIZE1];
  logic [CW-1:0] bi_mem  [SIZE2];
  logic [CW-1:0] tri_mem [SIZE3];
  logic [CW-1:0] uni_q;
  logic [CW-1:0] bi_q;
  logic [CW-1:0] tri_q;

  logic [CW-1:0]  count_r;
  logic [CW-1:0]  total_r;
  logic [CW-1:0]  rem;
  logic [FB-1:0]  quo;
  logic [DCW-1:0] dcnt;
  logic           zero_r;
  logic           full_r;
  logic [FB:0]    freq_r;

  // letter decode
  logic           is_upper;
  logic           is_lower;
  logic [7:0]     offs;
  logic           letter_ok;
  logic [AW1-1:0] li;

  assign is_upper  = (byte_r >= CHAR_UPPER_A) && (byte_r <= CHAR_UPPER_Z);
  assign is_lower  = (byte_r >= CHAR_LOWER_A) && (byte_r <= CHAR_LOWER_Z);
  assign offs      = is_upper ? (byte_r - CHAR_UPPER_A) : (byte_r - CHAR_LOWER_A);
  assign letter_ok = (is_upper || is_lower) && (offs < 8'(SIZE1));
  assign li        = offs[AW1-1:0];

  // addresses
  logic [AW1-1:0] f_uni;
  logic [AW2-1:0] f_bi;
  logic [AW3-1:0] f_tri;
  logic [AW1-1:0] uni_raddr;
  logic [AW2-1:0] bi_raddr;
  logic [AW3-1:0] tri_raddr;

  assign f_uni = li;
  assign f_bi  = AW2'(SIZE1 * prev) + AW2'(li);
  assign f_tri = AW3'(SIZE2 * sp) + AW3'(SIZE1 * prev) + AW3'(li);

  assign uni_raddr = (op_r == OP_FEED) ? f_uni : idx_r[AW1-1:0];
  assign bi_raddr  = (op_r == OP_FEED) ? f_bi  : idx_r[AW2-1:0];
  assign tri_raddr = (op_r == OP_FEED) ? f_tri : idx_r[AW3-1:0];

  // write ports: clearing sweep or feed update
  logic           uni_we;
  logic           bi_we;
  logic           tri_we;
  logic [AW1-1:0] uni_waddr;
  logic [AW2-1:0] bi_waddr;
  logic [AW3-1:0] tri_waddr;
  logic [CW-1:0]  uni_wdata;
  logic [CW-1:0]  bi_wdata;
  logic [CW-1:0]  tri_wdata;
  logic           feed_hit;

  assign feed_hit  = cmd.feed_wr && letter_ok;
  assign uni_we    = cmd.clr_step ? (sweep < AW3'(SIZE1)) : feed_hit;
  assign bi_we     = cmd.clr_step ? (sweep < AW3'(SIZE2)) : (feed_hit && prev_v);
  assign tri_we    = cmd.clr_step ? 1'b1 : (feed_hit && prev_v && sp_v);
  assign uni_waddr = cmd.clr_step ? sweep[AW1-1:0] : f_uni;
  assign bi_waddr  = cmd.clr_step ? sweep[AW2-1:0] : f_bi;
  assign tri_waddr = cmd.clr_step ? sweep : f_tri;
  assign uni_wdata = cmd.clr_step ? '0 : sat_inc(uni_q);
  assign bi_wdata  = cmd.clr_step ? '0 : sat_inc(bi_q);
  assign tri_wdata = cmd.clr_step ? '0 : sat_inc(tri_q);

  always_ff @(posedge clk) begin
    if (uni_we) uni_mem[uni_waddr] <= uni_wdata;
    if (cmd.mem_rd) uni_q <= uni_mem[uni_raddr];
  end

  always_ff @(posedge clk) begin
    if (bi_we) bi_mem[bi_waddr] <= bi_wdata;
    if (cmd.mem_rd) bi_q <= bi_mem[bi_raddr];
  end

  always_ff @(posedge clk) begin
    if (tri_we) tri_mem[tri_waddr] <= tri_wdata;
    if (cmd.mem_rd) tri_q <= tri_mem[tri_raddr];
  end

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r   <= operation;
      byte_r <= char_byte;
      sel_r  <= table_select;
      idx_r  <= entry_index;
    end
  end

  // totals, history, sweep counter
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_start) begin
      uni_tot <= '0;
      bi_tot  <= '0;
      tri_tot <= '0;
      prev    <= '0;
      prev_v  <= 1'b0;
      sp      <= '0;
      sp_v    <= 1'b0;
      sweep   <= '0;
    end else begin
      if (cmd.clr_step) sweep <= sweep + 1'b1;
      if (feed_hit) begin
        uni_tot <= sat_inc(uni_tot);
        if (prev_v) bi_tot <= sat_inc(bi_tot);
        if (prev_v && sp_v) tri_tot <= sat_inc(tri_tot);
        sp     <= prev;
        sp_v   <= prev_v;
        prev   <= li;
        prev_v <= 1'b1;
      end
    end
  end

  // readout selection
  logic [CW-1:0] cap_count;
  logic [CW-1:0] cap_total;

  always_comb begin
    unique case (sel_r)
      TBL_UNI: begin
        cap_total = uni_tot;
        cap_count = ({1'b0, idx_r} < 16'(SIZE1)) ? uni_q : '0;
      end
      TBL_BI: begin
        cap_total = bi_tot;
        cap_count = ({1'b0, idx_r} < 16'(SIZE2)) ? bi_q : '0;
      end
      TBL_TRI: begin
        cap_total = tri_tot;
        cap_count = ({1'b0, idx_r} < 16'(SIZE3)) ? tri_q : '0;
      end
      default: begin
        cap_total = '0;
        cap_count = '0;
      end
    endcase
  end

  // restoring divider, one quotient bit per cycle
  logic [CW:0] rem_sh;
  logic        div_ge;
  logic [CW:0] rnd_diff;
  logic        rnd_up;
  logic [FB:0] q_rnd;

  assign rem_sh   = {rem, 1'b0};
  assign div_ge   = rem_sh >= {1'b0, total_r};
  assign rnd_diff = {1'b0, total_r} - {1'b0, rem};
  assign rnd_up   = {1'b0, rem} >= rnd_diff;
  assign q_rnd    = {1'b0, quo} + (FB + 1)'(rnd_up);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      count_r <= cap_count;
      total_r <= cap_total;
      zero_r  <= (cap_total == '0);
      full_r  <= (cap_count >= cap_total);
      rem     <= cap_count;
      quo     <= '0;
      dcnt    <= '0;
    end else if (cmd.div_step) begin
      rem  <= div_ge ? CW'(rem_sh - {1'b0, total_r}) : rem_sh[CW-1:0];
      quo  <= {quo[FB-2:0], div_ge};
      dcnt <= dcnt + 1'b1;
    end
    if (cmd.round) begin
      freq_r <= zero_r ? '0 : (full_r ? FREQ_ONE : q_rnd);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      letter_accepted <= (op_r == OP_FEED) && letter_ok;
      entry_count     <= (op_r == OP_READ) ? count_r : '0;
      table_total     <= (op_r == OP_READ) ? total_r : '0;
      frequency_q16   <= (op_r == OP_READ) ? freq_r : '0;
      zero_total      <= (op_r == OP_READ) && zero_r;
    end
  end

  assign sts.op         = op_r;
  assign sts.sweep_done = (sweep == AW3'(SIZE3 - 1));
  assign sts.div_last   = (dcnt == DCW'(FB - 1));

  a_history_order: assert property (@(posedge clk) disable iff (rst)
    sp_v |-> prev_v)
    else $error("second history letter valid without first");

  a_total_order: assert property (@(posedge clk) disable iff (rst)
    (tri_tot <= bi_tot) && (bi_tot <= uni_tot))
    else $error("n-gram totals out of order");

  a_history_shift: assert property (@(posedge clk) disable iff (rst)
    feed_hit |=> prev_v && (prev == $past(li)))
    else $error("history not shifted after a letter");

endmodule

FILE: src/letter_ngram_histogram.sv
// ----------------------------------------------------------------------------
// letter_ngram_histogram
// Feed: memory read, then write of the incremented count; no new request is taken before the result is loaded.
// Read: memory read and capture, then the one-bit-per-cycle divider and rounding.
// Clear: sweeps all ALPHABET_SIZE^3 trigram entries, one trigram entry zeroed per cycle.
// Reset: runs the same sweep with s_axis_tready low.
// ----------------------------------------------------------------------------
module letter_ngram_histogram
  import lngh_pkg::*;
#(
  parameter int ALPHABET_SIZE = 26,
  parameter int COUNT_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // char_byte[7:0], entry_index[22:8], zero fill [23]
  input  logic [23:0]                            s_axis_tdata,
  // operation[1:0], table_select[3:2]
  input  logic [3:0]                             s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // entry_count, table_total, frequency_q16, zero fill to whole bytes
  output logic [((2*COUNT_WIDTH+FRACTION_BITS+8)/8)*8-1:0] m_axis_tdata,
  // letter_accepted[0], zero_total[1]
  output logic [1:0]                             m_axis_tuser
);

  localparam int ODW = ((2 * COUNT_WIDTH + FRACTION_BITS + 8) / 8) * 8;

  dp_cmd_t    cmd;
  dp_status_t sts;

  logic                     letter_accepted;
  logic [COUNT_WIDTH-1:0]   entry_count;
  logic [COUNT_WIDTH-1:0]   table_total;
  logic [FRACTION_BITS:0]   frequency_q16;
  logic                     zero_total;

  lngh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  lngh_datapath #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .COUNT_WIDTH   (COUNT_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .operation       (s_axis_tuser[1:0]),
    .char_byte       (s_axis_tdata[7:0]),
    .table_select    (s_axis_tuser[3:2]),
    .entry_index     (s_axis_tdata[22:8]),
    .letter_accepted (letter_accepted),
    .entry_count     (entry_count),
    .table_total     (table_total),
    .frequency_q16   (frequency_q16),
    .zero_total      (zero_total)
  );

  assign m_axis_tdata = ODW'({frequency_q16, table_total, entry_count});
  assign m_axis_tuser = {zero_total, letter_accepted};

endmodule
